// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl of the integer to ascii radix unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("property violated");

// condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: hw/rtl/itoa_pkg.sv
// constants, types and helpers for the integer to ascii radix unit
// no dependencies
`default_nettype none

package itoa_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int TEXT_SLOTS  = VALUE_BITS + 1;
  localparam int ADDR_W      = $clog2(TEXT_SLOTS);
  localparam int LEN_W       = $clog2(TEXT_SLOTS + 1);
  localparam int FIELD_W     = 6;
  localparam int CMP_W       = ((LEN_W > FIELD_W) ? LEN_W : FIELD_W) + 1;
  localparam int CNT_W       = $clog2(VALUE_BITS + 1);
  localparam int CHAR_W      = 7;

  localparam int RADIX_MIN   = 2;
  localparam int RADIX_MAX   = "z" - "a" + 1 + "9" - "0" + 1;
  localparam int DIGIT_LIMIT = 10;
  localparam int LETTER_BASE = "A" - 10;

  localparam logic [CHAR_W-1:0] CH_ERROR = CHAR_W'("#");
  localparam logic [CHAR_W-1:0] CH_PAD   = CHAR_W'(" ");
  localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'("-");
  localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'("0");

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [FIELD_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [VALUE_BITS-1:0] quotient;
    logic [FIELD_W-1:0]    remainder;
  } div_rsp_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [FIELD_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < FIELD_W'(DIGIT_LIMIT)) begin
      c = CH_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_W'(LETTER_BASE) + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/itoa_in_if.sv
// input item channel of the integer to ascii radix unit
// depends on itoa_pkg
`default_nettype none

interface itoa_in_if;
  import itoa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] magnitude;
  logic [FIELD_W-1:0]    radix;
  logic [FIELD_W-1:0]    min_width;
  logic [FIELD_W-1:0]    max_width;
  logic                  negative;

  modport source (
    output valid, magnitude, radix, min_width, max_width, negative,
    input  ready
  );

  modport sink (
    input  valid, magnitude, radix, min_width, max_width, negative,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/itoa_out_if.sv
// output character channel of the integer to ascii radix unit
// depends on itoa_pkg
`default_nettype none

interface itoa_out_if;
  import itoa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (
    output valid, character, last,
    input  ready
  );

  modport sink (
    input  valid, character, last,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/itoa_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on itoa_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module itoa_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itoa_pkg::div_req_t req_i,
  output itoa_pkg::div_rsp_t rsp_o
);
  import itoa_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [FIELD_W-1:0]    rem_q, rem_d;
  logic [FIELD_W-1:0]    div_q, div_d;

  logic [FIELD_W:0]      trial;
  logic [FIELD_W:0]      diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(VALUE_BITS);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
      quo_d = {quo_q[VALUE_BITS-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  `ASSERT_PROP(a_start_busy, clk_i, rst_ni, req_i.start |=> busy_q)
  `ASSERT_PROP(a_done_after_run, clk_i, rst_ni, done_q |-> ($past(busy_q) && !busy_q))
  `ASSERT_NEVER(a_busy_no_count, clk_i, rst_ni, busy_q && (cnt_q == '0))

endmodule

`default_nettype wire

// File: hw/rtl/integer_to_ascii_radix_unit.sv
// integer to ascii radix unit: one item in, 1 to 33 characters out, msd first
// per digit a start, 32 divider steps and a write-back on the shared divider
// then per character a text memory read, a load and a hold until the sink is ready
// input ready only when fully idle
// asynchronous active-low reset returns the sequencer to idle with no output pending
// depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_divider, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module integer_to_ascii_radix_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  itoa_in_if.sink     in_i,
  itoa_out_if.source  out_o
);
  import itoa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_PAD,
    ST_TRIM,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_HOLD
  } state_e;

  state_e                state_q, state_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic [FIELD_W-1:0]    radix_q, radix_d;
  logic [LEN_W-1:0]      minw_q, minw_d;
  logic [FIELD_W-1:0]    maxw_q, maxw_d;
  logic                  neg_q, neg_d;
  logic [LEN_W-1:0]      pos_q, pos_d;
  logic [ADDR_W-1:0]     rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0]     end_idx_q, end_idx_d;
  logic                  trunc_q, trunc_d;
  logic [CHAR_W-1:0]     char_q, char_d;
  logic                  last_q, last_d;
  logic                  ovalid_q, ovalid_d;

  logic [CHAR_W-1:0]     text_mem [TEXT_SLOTS];
  logic [CHAR_W-1:0]     rdata_q;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [CHAR_W-1:0]     mem_wdata;
  logic                  rd_en;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic                  radix_ok;
  logic [CMP_W-1:0]      text_len;

  itoa_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign radix_ok = (in_i.radix >= FIELD_W'(RADIX_MIN)) && (in_i.radix <= FIELD_W'(RADIX_MAX));
  assign text_len = CMP_W'(TEXT_SLOTS) - CMP_W'(pos_q);

  always_comb begin
    state_d   = state_q;
    value_d   = value_q;
    radix_d   = radix_q;
    minw_d    = minw_q;
    maxw_d    = maxw_q;
    neg_d     = neg_q;
    pos_d     = pos_q;
    rd_idx_d  = rd_idx_q;
    end_idx_d = end_idx_q;
    trunc_d   = trunc_q;
    char_d    = char_q;
    last_d    = last_q;
    ovalid_d  = ovalid_q;
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(pos_q - 1'b1);
    mem_wdata = CH_ZERO;
    rd_en     = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = value_q;
    div_req.divisor  = radix_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          value_d = in_i.magnitude;
          radix_d = in_i.radix;
          neg_d   = in_i.negative;
          minw_d  = (CMP_W'(in_i.min_width) > CMP_W'(VALUE_BITS)) ?
                    LEN_W'(VALUE_BITS) : LEN_W'(in_i.min_width);
          maxw_d  = (in_i.max_width == '0) ? FIELD_W'(1) : in_i.max_width;
          mem_waddr = ADDR_W'(TEXT_SLOTS - 1);
          if (!radix_ok) begin
            mem_we    = 1'b1;
            mem_wdata = CH_ERROR;
            pos_d     = LEN_W'(TEXT_SLOTS - 1);
            state_d   = ST_TRIM;
          end else if (in_i.magnitude == '0) begin
            // zero takes no sign
            mem_we    = 1'b1;
            mem_wdata = CH_ZERO;
            pos_d     = LEN_W'(TEXT_SLOTS - 1);
            state_d   = ST_PAD;
          end else begin
            pos_d   = LEN_W'(TEXT_SLOTS);
            state_d = ST_DIV_GO;
          end
        end
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_wdata = digit_char(div_rsp.remainder);
          pos_d     = pos_q - 1'b1;
          value_d   = div_rsp.quotient;
          state_d   = (div_rsp.quotient == '0) ? ST_SIGN : ST_DIV_GO;
        end
      end
      ST_SIGN: begin
        if (neg_q) begin
          mem_we    = 1'b1;
          mem_wdata = CH_MINUS;
          pos_d     = pos_q - 1'b1;
        end
        state_d = ST_PAD;
      end
      ST_PAD: begin
        if (text_len < CMP_W'(minw_q)) begin
          mem_we    = 1'b1;
          mem_wdata = CH_PAD;
          pos_d     = pos_q - 1'b1;
        end else begin
          state_d = ST_TRIM;
        end
      end
      ST_TRIM: begin
        rd_idx_d = ADDR_W'(pos_q);
        if (text_len > CMP_W'(maxw_q)) begin
          end_idx_d = ADDR_W'(CMP_W'(pos_q) + CMP_W'(maxw_q) - 1'b1);
          trunc_d   = 1'b1;
        end else begin
          end_idx_d = ADDR_W'(TEXT_SLOTS - 1);
          trunc_d   = 1'b0;
        end
        state_d = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        // cut text ends in the error mark
        char_d   = (trunc_q && (rd_idx_q == end_idx_q)) ? CH_ERROR : rdata_q;
        last_d   = rd_idx_q == end_idx_q;
        ovalid_d = 1'b1;
        state_d  = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (out_o.ready) begin
          ovalid_d = 1'b0;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
            state_d  = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      value_q   <= '0;
      radix_q   <= '0;
      minw_q    <= '0;
      maxw_q    <= '0;
      neg_q     <= 1'b0;
      pos_q     <= '0;
      rd_idx_q  <= '0;
      end_idx_q <= '0;
      trunc_q   <= 1'b0;
      char_q    <= '0;
      last_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      value_q   <= value_d;
      radix_q   <= radix_d;
      minw_q    <= minw_d;
      maxw_q    <= maxw_d;
      neg_q     <= neg_d;
      pos_q     <= pos_d;
      rd_idx_q  <= rd_idx_d;
      end_idx_q <= end_idx_d;
      trunc_q   <= trunc_d;
      char_q    <= char_d;
      last_q    <= last_d;
      ovalid_q  <= ovalid_d;
    end
  end

  // text memory, filled from the least significant end downward
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= text_mem[rd_idx_q];
    end
  end

  assign in_i.ready      = state_q == ST_IDLE;
  assign out_o.valid     = ovalid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  `ASSERT_PROP(a_valid_in_hold, clk_i, rst_ni, out_o.valid |-> (state_q == ST_EMIT_HOLD))
  `ASSERT_NEVER(a_ready_and_valid, clk_i, rst_ni, in_i.ready && out_o.valid)
  `ASSERT_NEVER(a_write_underflow, clk_i, rst_ni, mem_we && (state_q != ST_IDLE) && (pos_q == '0))

endmodule

`default_nettype wire
